FILE: design/hsc_pkg.sv
// constants, types and helpers for the hamming single error correcting codec
package hsc_pkg;

   localparam int WORD_W        = 63;
   localparam int SYN_W         = 6;
   localparam int K_W           = 6;
   localparam int CHK_MAX       = 6;
   localparam int MAX_DATA_BITS = 57;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [K_W-1:0] K_RESET = K_W'(4);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [K_W-1:0]    len_type;
   typedef logic [SYN_W-1:0]  syn_type;

   // position p (0-based) holds a check bit when p+1 is a power of two
   function automatic logic is_check_pos(input int pos);
      int idx;
      idx = pos + 1;
      return (idx & (idx - 1)) == 0;
   endfunction

   // positions covered by check bit i
   function automatic word_type group_mask(input int i);
      word_type m;
      m = '0;
      for (int j = 0; j < WORD_W; j++) begin
         m[j] = (((j + 1) >> i) & 1) == 1;
      end
      return m;
   endfunction

   // clamp the written length into 1 .. MAX_DATA_BITS
   function automatic len_type clamp_k(input len_type raw);
      len_type k;
      k = raw;
      if (k == '0) begin
         k = len_type'(1);
      end
      if (k > len_type'(MAX_DATA_BITS)) begin
         k = len_type'(MAX_DATA_BITS);
      end
      return k;
   endfunction

   // least r with 2^r >= k + r + 1
   function automatic logic [2:0] check_count(input len_type k);
      logic [2:0] r;
      logic       done;
      r    = '0;
      done = 1'b0;
      for (int t = 0; t < 7; t++) begin
         if (!done && ((8'd1 << t) < (8'(k) + 8'(t) + 8'd1))) begin
            r = 3'(t + 1);
         end else begin
            done = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

FILE: design/hamming_sec_codec_unit.sv
// top level of the hamming single error correcting codec
// A word is taken on every clock edge where start is high (busy is always low)
// and its result appears, via the input and result registers, for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall, so results must be taken as they come.
// One word per cycle is sustained: an input register feeds one pass of
// parity trees, correction and bit gathering into the result register.
// mode 0 encodes the low k bits of req_word into an n-bit codeword; mode 1
// decodes an n-bit codeword, flipping the bit named by a syndrome in 1..n.
// csr_data_bits sets k (0 reads as 1, values above 57 saturate); the check
// count and codeword length are worked out when it is written. Write it only
// while no word is in flight; csr_ready is always high.
module hamming_sec_codec_unit
   import hsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // command side
   input  logic             start,
   output logic             busy,
   input  logic             req_mode,
   input  logic [WORD_W-1:0] req_word,
   // result side
   output logic             rsp_valid,
   output logic [WORD_W-1:0] rsp_result_word,
   output logic             rsp_corrected,
   output logic [SYN_W-1:0] rsp_syndrome,
   // length register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [K_W-1:0]   csr_data_bits
);

   // length registers: k and n are held already resolved
   len_type k_ff, k_in;
   len_type n_ff, n_in;

   // input stage
   logic     s1_valid_ff;
   logic     s1_mode_ff;
   word_type s1_word_ff;

   // result stage
   logic     rsp_valid_ff;
   word_type rsp_word_ff, rsp_word_in;
   logic     rsp_corr_ff, rsp_corr_in;
   syn_type  rsp_syn_ff, rsp_syn_in;

   // datapath nets
   word_type scat;
   word_type code;
   word_type src;
   word_type flipped;
   word_type gathered;
   word_type enc_word;
   syn_type  syn;
   logic     fix;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // resolve k and n from the written value
   always_comb begin
      k_in = clamp_k(csr_data_bits);
      n_in = k_in + len_type'(check_count(k_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
         n_ff <= K_RESET + len_type'(check_count(K_RESET));
      end else if (csr_valid && csr_ready) begin
         k_ff <= k_in;
         n_ff <= n_in;
      end
   end

   // capture the command word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         s1_mode_ff <= req_mode;
         s1_word_ff <= req_word;
      end
   end

   // scatter data bits onto the non-check positions, dropping bits at or above k
   always_comb begin
      automatic int d = 0;
      scat = '0;
      for (int p = 0; p < WORD_W; p++) begin
         if (!is_check_pos(p)) begin
            scat[p] = s1_word_ff[d] && (len_type'(d) < k_ff);
            d++;
         end
      end
   end

   // received codeword, bits at or above n ignored
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         code[j] = s1_word_ff[j] && (len_type'(j) < n_ff);
      end
   end

   // one parity tree per check bit; the same trees serve both directions
   assign src = (s1_mode_ff == MODE_DECODE) ? code : scat;

   always_comb begin
      for (int i = 0; i < CHK_MAX; i++) begin
         syn[i] = ^(src & group_mask(i));
      end
   end

   // encode: drop each parity into its power-of-two slot
   always_comb begin
      enc_word = scat;
      for (int i = 0; i < CHK_MAX; i++) begin
         enc_word[(1 << i) - 1] = syn[i];
      end
   end

   // decode: flip the named bit when the syndrome lies inside the codeword
   assign fix = (syn != '0) && (syn <= n_ff);

   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         flipped[j] = code[j] ^ (fix && (syn == syn_type'(j + 1)));
      end
   end

   // gather the data positions back down to the low bits
   always_comb begin
      automatic int d = 0;
      gathered = '0;
      for (int p = 0; p < WORD_W; p++) begin
         if (!is_check_pos(p)) begin
            gathered[d] = flipped[p];
            d++;
         end
      end
   end

   always_comb begin
      if (s1_mode_ff == MODE_DECODE) begin
         rsp_word_in = gathered;
         rsp_corr_in = fix;
         rsp_syn_in  = syn;
      end else begin
         rsp_word_in = enc_word;
         rsp_corr_in = 1'b0;
         rsp_syn_in  = '0;
      end
   end

   // result register, shown for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
         rsp_corr_ff <= rsp_corr_in;
         rsp_syn_ff  <= rsp_syn_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_corrected   = rsp_corr_ff;
   assign rsp_syndrome    = rsp_syn_ff;

   // an accepted command word always yields a result, via the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing two cycles after command");

   // an encode result never reports a correction or a syndrome
   a_encode_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_mode_ff == MODE_ENCODE) |=>
         (!rsp_corrected && rsp_syndrome == '0))
      else $error("encode result carries decode status");

   // a correction only ever names a position inside the codeword
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_corrected) |->
         (rsp_syndrome != '0 && rsp_syndrome <= n_ff))
      else $error("correction outside codeword");

   // the held length stays within its legal range and n tracks k
   a_len: assert property (@(posedge clock) disable iff (reset)
      (k_ff >= len_type'(1) && k_ff <= len_type'(MAX_DATA_BITS) &&
       n_ff == k_ff + len_type'(check_count(k_ff))))
      else $error("length registers inconsistent");

endmodule
